// File: design/rdtm_pkg.sv
// Shared constants, codes and types of the relative-difference template matcher.
package rdtm_pkg;

	localparam int PIC_SIDE = 256;
	localparam int PAT_SIDE = 32;
	localparam int PIX_W    = 8;
	localparam int FRAC_W   = 16;
	localparam int TERM_W   = PIX_W + FRAC_W;
	localparam int SUM_W    = 34;
	localparam int POS_W    = $clog2(PIC_SIDE);
	localparam int IJ_W     = $clog2(PAT_SIDE);
	localparam int PIC_AW   = 2 * POS_W;
	localparam int PAT_AW   = 2 * IJ_W;
	localparam int N_W      = POS_W + 1;
	localparam int M_W      = IJ_W + 1;
	localparam int MM_W     = 2 * M_W;
	localparam int THR_W    = 16;
	localparam int LIM_W    = THR_W + MM_W;
	localparam int CNT_W    = 4;
	localparam int TAG_W    = 16;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};

	// Register indexes (word address bits)
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_PIC_SIZE  = 2'd1;
	localparam logic [1:0] REG_PAT_SIZE  = 2'd2;
	localparam logic [1:0] REG_MAX_OBJ   = 2'd3;

	typedef enum logic [1:0] {
		ACT_PIC  = 2'd0,
		ACT_PAT  = 2'd1,
		ACT_SCAN = 2'd2,
		ACT_NEW  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MM,
		ST_LIMIT,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT,
		ST_ADV,
		ST_DONE,
		ST_FIN
	} state_t;

	// Data handed from one divider cell to the next
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              pz;
		logic              oz;
		logic [PIX_W-1:0]  p;
		logic [TERM_W-1:0] dvd;
		logic [PIX_W-1:0]  rem;
		logic [TERM_W-1:0] quo;
	} cell_t;

endpackage

// File: design/rdtm_div_cell.sv
// One restoring-division cell: develops one quotient bit and hands on to the next cell.
module rdtm_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  rdtm_pkg::cell_t cell_in,
	output rdtm_pkg::cell_t cell_out
);

	rdtm_pkg::cell_t          nxt;
	rdtm_pkg::cell_t          cell_q;
	logic [rdtm_pkg::PIX_W:0] rem2;
	logic [rdtm_pkg::PIX_W:0] diff;
	logic                     ge;

	// shift in next dividend bit, subtract divisor when it fits
	always_comb begin
		rem2 = {cell_in.rem, cell_in.dvd[rdtm_pkg::TERM_W-1]};
		diff = rem2 - {1'b0, cell_in.p};
		ge   = (rem2 >= {1'b0, cell_in.p});
		nxt      = cell_in;
		nxt.dvd  = {cell_in.dvd[rdtm_pkg::TERM_W-2:0], 1'b0};
		nxt.rem  = ge ? diff[rdtm_pkg::PIX_W-1:0] : rem2[rdtm_pkg::PIX_W-1:0];
		nxt.quo  = {cell_in.quo[rdtm_pkg::TERM_W-2:0], ge};
	end

	// advance one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else begin
			cell_q <= nxt;
		end
	end

	assign cell_out = cell_q;

endmodule

// File: design/rdtm_div_chain.sv
// Row of divider cells that turns |p-o| and p into one relative-difference term per cycle.
module rdtm_div_chain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rdtm_pkg::cell_t             head,
	output logic                        term_valid,
	output logic                        term_last,
	output logic [rdtm_pkg::TERM_W-1:0] term
);

	rdtm_pkg::cell_t link [rdtm_pkg::TERM_W+1];
	rdtm_pkg::cell_t tail;

	assign link[0] = head;

	for (genvar k = 0; k < rdtm_pkg::TERM_W; k++) begin : g_cell
		rdtm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_in  (link[k]),
			.cell_out (link[k+1])
		);
	end

	assign tail = link[rdtm_pkg::TERM_W];

	// zero picture pixel: zero term on equal pixels, else saturate
	always_comb begin
		term_valid = tail.valid;
		term_last  = tail.last;
		if (tail.pz) begin
			term = tail.oz ? '0 : rdtm_pkg::TERM_MAX;
		end else begin
			term = tail.quo;
		end
	end

endmodule

// File: design/relative_difference_template_matcher.sv
// Top level: register port, pixel stores, window sequencer, divider chain and result register.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------------
//  item      | item_valid / item_ready    | action, row, col, pixel, pattern_tag
//  result    | result_valid / result_ready| found, match_pattern, match_row, match_col,
//            |                            | score_sum, last
//  register  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Load and new-picture items are taken while idle. A scan runs setup states MM and LIMIT,
// then per window issues M*M pixel reads, drains the read stage and the 24-cell divider
// chain, waits in EMIT on each match and advances; the done result comes from DONE and FIN.
// A scan with no window to test or MAX_OBJ matches found goes straight to the done result.
// Reset clears control state and loads the register defaults; pixel stores are not cleared.
// Items are taken only while idle; a stalled result holds the scan in place.
module relative_difference_template_matcher (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rdtm_pkg::ADDR_W-1:0]         paddr,
	input  logic [rdtm_pkg::DATA_W-1:0]         pwdata,
	output logic [rdtm_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [1:0]                          action,
	input  logic [7:0]                          row,
	input  logic [7:0]                          col,
	input  logic [7:0]                          pixel,
	input  logic [rdtm_pkg::TAG_W-1:0]          pattern_tag,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                found,
	output logic [rdtm_pkg::TAG_W-1:0]          match_pattern,
	output logic [7:0]                          match_row,
	output logic [7:0]                          match_col,
	output logic [rdtm_pkg::SUM_W-1:0]          score_sum,
	output logic                                last
);

	// configuration
	logic [rdtm_pkg::THR_W-1:0] threshold_q;
	logic [rdtm_pkg::N_W-1:0]   pic_size_q;
	logic [rdtm_pkg::M_W-1:0]   pat_size_q;
	logic [rdtm_pkg::CNT_W-1:0] max_obj_q;
	logic                       cfg_wr;

	// control
	rdtm_pkg::state_t           state_q, state_nxt;
	logic                       item_acc;
	logic                       issue;
	logic [rdtm_pkg::CNT_W-1:0] found_q;
	logic [rdtm_pkg::TAG_W-1:0] tag_q;
	logic [rdtm_pkg::N_W-1:0]   n_q;
	logic [rdtm_pkg::M_W-1:0]   m_q;
	logic [rdtm_pkg::MM_W-1:0]  mm_q;
	logic [rdtm_pkg::LIM_W-1:0] limit_q;
	logic [rdtm_pkg::POS_W-1:0] r_q, c_q;
	logic [rdtm_pkg::IJ_W-1:0]  i_q, j_q;
	logic                       pix_last;
	logic                       j_end;
	logic                       scan_none;
	logic [rdtm_pkg::N_W:0]     c_reach, r_reach;
	logic                       c_fits, r_fits;
	logic [rdtm_pkg::N_W-1:0]   n_sat;
	logic [rdtm_pkg::M_W-1:0]   m_sat;
	logic                       is_match;

	// stores and read stage
	logic [rdtm_pkg::PIX_W-1:0] pic_mem [2**rdtm_pkg::PIC_AW];
	logic [rdtm_pkg::PIX_W-1:0] pat_mem [2**rdtm_pkg::PAT_AW];
	logic [rdtm_pkg::PIX_W-1:0] pic_s1, pat_s1;
	logic                       rd_valid_s1, rd_last_s1;
	logic [rdtm_pkg::PIC_AW-1:0] pic_raddr;
	logic [rdtm_pkg::PAT_AW-1:0] pat_raddr;
	logic [rdtm_pkg::POS_W-1:0] rr, cc;
	logic [rdtm_pkg::PIX_W-1:0] absd;
	rdtm_pkg::cell_t            head;

	// chain and accumulator
	logic                        term_valid, term_last;
	logic [rdtm_pkg::TERM_W-1:0] term;
	logic [rdtm_pkg::SUM_W-1:0]  sum_q, wsum_q, sum_add;
	logic                        wdone_q;

	// result register
	logic                       res_valid_q;
	logic                       res_found_q, res_last_q;
	logic [rdtm_pkg::TAG_W-1:0] res_tag_q;
	logic [7:0]                 res_row_q, res_col_q;
	logic [rdtm_pkg::SUM_W-1:0] res_sum_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= rdtm_pkg::THR_W'(6554);
			pic_size_q  <= rdtm_pkg::N_W'(256);
			pat_size_q  <= rdtm_pkg::M_W'(32);
			max_obj_q   <= rdtm_pkg::CNT_W'(3);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				rdtm_pkg::REG_THRESHOLD: threshold_q <= pwdata[rdtm_pkg::THR_W-1:0];
				rdtm_pkg::REG_PIC_SIZE:  pic_size_q  <= pwdata[rdtm_pkg::N_W-1:0];
				rdtm_pkg::REG_PAT_SIZE:  pat_size_q  <= pwdata[rdtm_pkg::M_W-1:0];
				rdtm_pkg::REG_MAX_OBJ:   max_obj_q   <= pwdata[rdtm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rdtm_pkg::REG_THRESHOLD: prdata = rdtm_pkg::DATA_W'(threshold_q);
			rdtm_pkg::REG_PIC_SIZE:  prdata = rdtm_pkg::DATA_W'(pic_size_q);
			rdtm_pkg::REG_PAT_SIZE:  prdata = rdtm_pkg::DATA_W'(pat_size_q);
			rdtm_pkg::REG_MAX_OBJ:   prdata = rdtm_pkg::DATA_W'(max_obj_q);
			default:                 prdata = '0;
		endcase
	end

	// sizes clipped to the stores, scan bounds
	always_comb begin
		n_sat = (pic_size_q > rdtm_pkg::N_W'(rdtm_pkg::PIC_SIDE)) ?
			rdtm_pkg::N_W'(rdtm_pkg::PIC_SIDE) : pic_size_q;
		m_sat = (pat_size_q > rdtm_pkg::M_W'(rdtm_pkg::PAT_SIDE)) ?
			rdtm_pkg::M_W'(rdtm_pkg::PAT_SIDE) : pat_size_q;
		scan_none = (n_sat == '0) || (m_sat == '0) ||
			({{(rdtm_pkg::N_W-rdtm_pkg::M_W){1'b0}}, m_sat} > n_sat) ||
			(found_q >= max_obj_q);
		c_reach = {2'b0, c_q} + (rdtm_pkg::N_W+1)'(1) + (rdtm_pkg::N_W+1)'(m_q);
		r_reach = {2'b0, r_q} + (rdtm_pkg::N_W+1)'(1) + (rdtm_pkg::N_W+1)'(m_q);
		c_fits  = (c_reach <= {1'b0, n_q});
		r_fits  = (r_reach <= {1'b0, n_q});
		j_end    = ({1'b0, j_q} == m_q - rdtm_pkg::M_W'(1));
		pix_last = j_end && ({1'b0, i_q} == m_q - rdtm_pkg::M_W'(1));
		is_match = (wsum_q <= rdtm_pkg::SUM_W'(limit_q));
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rdtm_pkg::ST_IDLE: begin
				if (item_valid && action == rdtm_pkg::ACT_SCAN) begin
					state_nxt = scan_none ? rdtm_pkg::ST_DONE : rdtm_pkg::ST_MM;
				end
			end
			rdtm_pkg::ST_MM:    state_nxt = rdtm_pkg::ST_LIMIT;
			rdtm_pkg::ST_LIMIT: state_nxt = rdtm_pkg::ST_RUN;
			rdtm_pkg::ST_RUN: begin
				if (pix_last) begin
					state_nxt = rdtm_pkg::ST_DRAIN;
				end
			end
			rdtm_pkg::ST_DRAIN: begin
				if (wdone_q) begin
					state_nxt = is_match ? rdtm_pkg::ST_EMIT : rdtm_pkg::ST_ADV;
				end
			end
			rdtm_pkg::ST_EMIT: begin
				if (result_ready) begin
					state_nxt = rdtm_pkg::ST_ADV;
				end
			end
			rdtm_pkg::ST_ADV: begin
				if ((!c_fits && !r_fits) || (found_q >= max_obj_q)) begin
					state_nxt = rdtm_pkg::ST_DONE;
				end else begin
					state_nxt = rdtm_pkg::ST_RUN;
				end
			end
			rdtm_pkg::ST_DONE: state_nxt = rdtm_pkg::ST_FIN;
			rdtm_pkg::ST_FIN: begin
				if (result_ready) begin
					state_nxt = rdtm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = rdtm_pkg::ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		item_ready = (state_q == rdtm_pkg::ST_IDLE);
		issue      = (state_q == rdtm_pkg::ST_RUN);
	end

	assign item_acc = item_valid && item_ready;

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdtm_pkg::ST_IDLE;
			found_q     <= '0;
			res_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			r_q         <= '0;
			c_q         <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				rdtm_pkg::ST_IDLE: begin
					if (item_acc && action == rdtm_pkg::ACT_NEW) begin
						found_q <= '0;
					end
					if (item_acc && action == rdtm_pkg::ACT_SCAN) begin
						r_q <= '0;
						c_q <= '0;
						i_q <= '0;
						j_q <= '0;
					end
				end
				rdtm_pkg::ST_RUN: begin
					if (j_end) begin
						j_q <= '0;
						i_q <= pix_last ? '0 : i_q + rdtm_pkg::IJ_W'(1);
					end else begin
						j_q <= j_q + rdtm_pkg::IJ_W'(1);
					end
				end
				rdtm_pkg::ST_DRAIN: begin
					if (wdone_q && is_match) begin
						found_q     <= found_q + rdtm_pkg::CNT_W'(1);
						res_valid_q <= 1'b1;
					end
				end
				rdtm_pkg::ST_EMIT: begin
					if (result_ready) begin
						res_valid_q <= 1'b0;
					end
				end
				rdtm_pkg::ST_ADV: begin
					if (c_fits) begin
						c_q <= c_q + rdtm_pkg::POS_W'(1);
					end else begin
						c_q <= '0;
						r_q <= r_q + rdtm_pkg::POS_W'(1);
					end
				end
				rdtm_pkg::ST_DONE: res_valid_q <= 1'b1;
				rdtm_pkg::ST_FIN: begin
					if (result_ready) begin
						res_valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// scan setup and result payload
	always_ff @(posedge clk) begin
		if (item_acc && action == rdtm_pkg::ACT_SCAN) begin
			tag_q <= pattern_tag;
			n_q   <= n_sat;
			m_q   <= m_sat;
		end
		if (state_q == rdtm_pkg::ST_MM) begin
			mm_q <= m_q * m_q;
		end
		if (state_q == rdtm_pkg::ST_LIMIT) begin
			limit_q <= threshold_q * mm_q;
		end
		if (state_q == rdtm_pkg::ST_DRAIN && wdone_q) begin
			res_found_q <= 1'b1;
			res_last_q  <= 1'b0;
			res_tag_q   <= tag_q;
			res_row_q   <= r_q;
			res_col_q   <= c_q;
			res_sum_q   <= wsum_q;
		end
		if (state_q == rdtm_pkg::ST_DONE) begin
			res_found_q <= 1'b0;
			res_last_q  <= 1'b1;
			res_tag_q   <= tag_q;
			res_row_q   <= '0;
			res_col_q   <= '0;
			res_sum_q   <= '0;
		end
	end

	// pixel stores: write on load transfers, registered read during the walk
	assign rr        = r_q + rdtm_pkg::POS_W'(i_q);
	assign cc        = c_q + rdtm_pkg::POS_W'(j_q);
	assign pic_raddr = {rr, cc};
	assign pat_raddr = {i_q, j_q};

	always_ff @(posedge clk) begin
		if (item_acc && action == rdtm_pkg::ACT_PIC) begin
			pic_mem[{row, col}] <= pixel;
		end
		pic_s1 <= pic_mem[pic_raddr];
	end

	always_ff @(posedge clk) begin
		if (item_acc && action == rdtm_pkg::ACT_PAT &&
			row < 8'(rdtm_pkg::PAT_SIDE) && col < 8'(rdtm_pkg::PAT_SIDE)) begin
			pat_mem[{row[rdtm_pkg::IJ_W-1:0], col[rdtm_pkg::IJ_W-1:0]}] <= pixel;
		end
		pat_s1 <= pat_mem[pat_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			rd_last_s1  <= issue && pix_last;
		end
	end

	// feed the divider chain with (|p-o| << 16) / p
	always_comb begin
		absd       = (pic_s1 > pat_s1) ? pic_s1 - pat_s1 : pat_s1 - pic_s1;
		head.valid = rd_valid_s1;
		head.last  = rd_last_s1;
		head.pz    = (pic_s1 == '0);
		head.oz    = (pat_s1 == '0);
		head.p     = pic_s1;
		head.dvd   = {absd, {rdtm_pkg::FRAC_W{1'b0}}};
		head.rem   = '0;
		head.quo   = '0;
	end

	rdtm_div_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.term_valid (term_valid),
		.term_last  (term_last),
		.term       (term)
	);

	// accumulate terms, hand over the window sum on its last pixel
	assign sum_add = sum_q + rdtm_pkg::SUM_W'(term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			wdone_q <= 1'b0;
		end else begin
			wdone_q <= term_valid && term_last;
			if (term_valid) begin
				sum_q <= term_last ? '0 : sum_add;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (term_valid && term_last) begin
			wsum_q <= sum_add;
		end
	end

	assign result_valid  = res_valid_q;
	assign found         = res_found_q;
	assign match_pattern = res_tag_q;
	assign match_row     = res_row_q;
	assign match_col     = res_col_q;
	assign score_sum     = res_sum_q;
	assign last          = res_last_q;

endmodule
